// ===== rtl/rk4_pkg.sv =====
//------------------------------------------------------------------------------
// RK4 integrator package
// Micro-op codes, the control word, the microprogram and the small
// arithmetic helpers (saturation, divide-by-three digit) of the integrator.
//------------------------------------------------------------------------------
`default_nettype none

package rk4_pkg;

  // Width of the microprogram counter
  localparam int UPC_W = 6;

  // Register map (word index, taken from paddr[2])
  localparam logic REG_STEP_SIZE  = 1'b0;
  localparam logic REG_STEP_COUNT = 1'b1;

  // Saturation bounds at the width of the internal sums
  localparam logic signed [65:0] SAT_MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN66 = -66'sd2147483648;

  // Datapath operations, one per microprogram step
  typedef enum logic [3:0] {
    OP_NOP,    // nothing, used by the step-count check
    OP_XM,     // xm = S(x + h/2), clear the slope sum
    OP_XE,     // xe = S(x + h)
    OP_YS,     // ys = S(y + 0, k/2 or k)
    OP_MSQ,    // product = xs * xs
    OP_RNDT,   // t = S(round(product))
    OP_SUB,    // t = S(ys - t)
    OP_ONE,    // t = S(t + 1.0)
    OP_MH,     // product = h * t
    OP_RNDK,   // k = S(round(product))
    OP_ACC,    // sum += k or 2k
    OP_DINIT,  // start of the divide by six
    OP_DITER,  // one quotient byte of the divide by three
    OP_KFIN,   // k = S(signed quotient)
    OP_YUPD,   // y = S(y + k), x = xe, count down
    OP_FIN     // hand the item to the output register
  } uop_t;

  // Source of the x operand of a stage
  typedef enum logic [1:0] {
    XS_X,
    XS_XM,
    XS_XE
  } xsel_t;

  // Share of the previous slope added to y at the start of a stage
  typedef enum logic [1:0] {
    KA_NONE,
    KA_HALF,
    KA_FULL
  } kadd_t;

  // Branch conditions of the sequencer
  typedef enum logic [2:0] {
    J_NEXT,      // fall through
    J_ALWAYS,    // unconditional jump
    J_CNT_ZERO,  // jump when no steps remain
    J_DIV_BUSY,  // jump while quotient bytes remain
    J_MORE,      // jump when another step follows
    J_OUT_WAIT   // hold until the output register is free
  } jcond_t;

  // One control word
  typedef struct packed {
    uop_t              op;
    xsel_t             xsel;
    kadd_t             kadd;
    logic              dbl;
    jcond_t            cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  // Saturation result
  typedef struct packed {
    logic              ov;
    logic signed [31:0] val;
  } sat_t;

  // Divide-by-three digit result
  typedef struct packed {
    logic [7:0] q;
    logic [1:0] rem;
  } d3_t;

  // Microprogram addresses
  localparam logic [UPC_W-1:0] UA_CHECK  = 6'd0;
  localparam logic [UPC_W-1:0] UA_XM     = 6'd1;
  localparam logic [UPC_W-1:0] UA_XE     = 6'd2;
  localparam logic [UPC_W-1:0] UA_STAGE0 = 6'd8;
  localparam logic [UPC_W-1:0] UA_DINIT  = 6'd40;
  localparam logic [UPC_W-1:0] UA_DITER  = 6'd41;
  localparam logic [UPC_W-1:0] UA_KFIN   = 6'd42;
  localparam logic [UPC_W-1:0] UA_YUPD   = 6'd43;
  localparam logic [UPC_W-1:0] UA_FIN    = 6'd44;

  // Microprogram ROM. The four slope stages occupy eight words each from
  // UA_STAGE0 on; the stage number is address bits 4:3 minus one (modulo four).
  function automatic uword_t ucode(input logic [UPC_W-1:0] a);
    uword_t     w;
    logic [1:0] stg;
    w = '{op: OP_NOP, xsel: XS_X, kadd: KA_NONE, dbl: 1'b0,
          cond: J_NEXT, target: '0};
    stg = a[4:3] - 2'd1;
    if (a >= UA_STAGE0 && a < UA_DINIT) begin
      case (stg)
        2'd0: begin
          w.xsel = XS_X;
          w.kadd = KA_NONE;
          w.dbl  = 1'b0;
        end
        2'd1: begin
          w.xsel = XS_XM;
          w.kadd = KA_HALF;
          w.dbl  = 1'b1;
        end
        2'd2: begin
          w.xsel = XS_XM;
          w.kadd = KA_HALF;
          w.dbl  = 1'b1;
        end
        default: begin
          w.xsel = XS_XE;
          w.kadd = KA_FULL;
          w.dbl  = 1'b0;
        end
      endcase
      case (a[2:0])
        3'd0:    w.op = OP_YS;
        3'd1:    w.op = OP_MSQ;
        3'd2:    w.op = OP_RNDT;
        3'd3:    w.op = OP_SUB;
        3'd4:    w.op = OP_ONE;
        3'd5:    w.op = OP_MH;
        3'd6:    w.op = OP_RNDK;
        default: w.op = OP_ACC;
      endcase
    end else begin
      case (a)
        UA_CHECK: begin
          w.cond   = J_CNT_ZERO;
          w.target = UA_FIN;
        end
        UA_XM: w.op = OP_XM;
        UA_XE: begin
          w.op     = OP_XE;
          w.cond   = J_ALWAYS;
          w.target = UA_STAGE0;
        end
        UA_DINIT: w.op = OP_DINIT;
        UA_DITER: begin
          w.op     = OP_DITER;
          w.cond   = J_DIV_BUSY;
          w.target = UA_DITER;
        end
        UA_KFIN: w.op = OP_KFIN;
        UA_YUPD: begin
          w.op     = OP_YUPD;
          w.cond   = J_MORE;
          w.target = UA_XM;
        end
        UA_FIN: begin
          w.op     = OP_FIN;
          w.cond   = J_OUT_WAIT;
          w.target = UA_FIN;
        end
        default: begin
          w.cond   = J_ALWAYS;
          w.target = UA_FIN;
        end
      endcase
    end
    return w;
  endfunction

  // Clamp a wide sum to the signed 32-bit range and flag the clamp
  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > SAT_MAX66) begin
      r.ov  = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < SAT_MIN66) begin
      r.ov  = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.ov  = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // One byte of long division by three: restoring steps on a 2-bit remainder
  function automatic d3_t div3_byte(input logic [1:0] rem_in, input logic [7:0] dig);
    d3_t        r;
    logic [2:0] t;
    logic [1:0] rm;
    rm = rem_in;
    r.q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {rm, dig[i]};
      if (t >= 3'd3) begin
        r.q[i] = 1'b1;
        rm     = 2'(t - 3'd3);
      end else begin
        r.q[i] = 1'b0;
        rm     = t[1:0];
      end
    end
    r.rem = rm;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rk4_ode_integrator.sv =====
//------------------------------------------------------------------------------
// RK4 ODE integrator
// Integrates y' = y - x*x + 1 from (start_x, start_y) with classic fourth-order
// Runge-Kutta in saturating signed fixed point, driven by a microprogram.
//------------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_stall    | in_start_x, in_start_y
//  result   | out_valid / out_stall  | out_end_x, out_end_y, out_overflow
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready high)
//
//  An item runs N = min(step_count, MAX_STEPS) steps.
//  Each step is one pass of the microprogram: one datapath operation per cycle,
//  both squarings and slope products on a single registered 32x32 multiplier,
//  and byte-wise long division for the divide by six.
//  Reset (rst_n low, synchronous) empties the block and restores step_size
//  to 0.2 and step_count to 10. in_stall is high while an item is in work;
//  a finished item waits in the output register under out_stall while the
//  next item is taken in.
//
`default_nettype none

module rk4_ode_integrator #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_STEPS = 1023
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  in_start_x,
  input  wire logic signed [31:0]  in_start_y,
  // result items
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_end_x,
  output logic signed [31:0]       out_end_y,
  output logic                     out_overflow,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import rk4_pkg::*;

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic signed [65:0] ONE      = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

  // Configuration registers
  logic [30:0]             step_size_r;
  logic [9:0]              step_count_r;

  // Sequencer
  logic                    busy_r, busy_nxt;
  logic [UPC_W-1:0]        upc_r, upc_nxt;
  uword_t                  uw;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Datapath registers
  logic signed [31:0]      x_r, x_nxt;
  logic signed [31:0]      y_r, y_nxt;
  logic signed [31:0]      xm_r, xm_nxt;
  logic signed [31:0]      xe_r, xe_nxt;
  logic signed [31:0]      ys_r, ys_nxt;
  logic signed [31:0]      t_r, t_nxt;
  logic signed [31:0]      k_r, k_nxt;
  logic signed [34:0]      acc_r, acc_nxt;
  logic signed [63:0]      p_r, p_nxt;
  logic [39:0]             dv_r, dv_nxt;
  logic [1:0]              drem_r, drem_nxt;
  logic [2:0]              dcnt_r, dcnt_nxt;
  logic                    dneg_r, dneg_nxt;
  logic                    ov_r, ov_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [31:0]      out_x_r;
  logic signed [31:0]      out_y_r;
  logic                    out_ov_r;

  // Datapath helpers
  logic                    in_acc;
  logic                    out_load;
  logic                    cfg_wr;
  logic signed [65:0]      h66;
  logic signed [65:0]      hhalf66;
  logic signed [65:0]      rnd66;
  logic signed [65:0]      q66;
  logic signed [65:0]      kadd66;
  logic signed [31:0]      xs;
  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [34:0]      kx;
  logic signed [35:0]      acc36;
  logic [35:0]             mag36;
  logic [CNT_W-1:0]        cnt_load;
  sat_t                    sr;
  d3_t                     dg;

  // Handshakes
  assign in_acc    = in_valid && !busy_r;
  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_end_x = out_x_r;
  assign out_end_y = out_y_r;
  assign out_overflow = out_ov_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Configuration write and read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= 31'd13107;
      step_count_r <= 10'd10;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STEP_SIZE:  step_size_r  <= pwdata[30:0];
        REG_STEP_COUNT: step_count_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP_SIZE:  prdata = {1'b0, step_size_r};
      REG_STEP_COUNT: prdata = {22'd0, step_count_r};
      default:        prdata = '0;
    endcase
  end

  // Current control word and the step count of a new item
  assign uw = ucode(upc_r);

  always_comb begin
    if (32'(step_count_r) > 32'(MAX_STEPS)) begin
      cnt_load = CNT_W'(MAX_STEPS);
    end else begin
      cnt_load = CNT_W'(step_count_r);
    end
  end

  // Operand selection and shared arithmetic
  assign h66     = $signed({35'd0, step_size_r});
  assign hhalf66 = $signed({36'd0, step_size_r[30:1]});
  assign rnd66   = ($signed({{2{p_r[63]}}, p_r}) + RND_HALF) >>> FRAC_BITS;
  assign q66     = $signed({33'd0, dv_r[32:0]});
  assign kx      = 35'(k_r);
  assign acc36   = 36'(acc_r);
  assign mag36   = (acc_r[34] ? 36'(-acc36) : 36'(acc36)) + 36'd3;
  assign dg      = div3_byte(drem_r, dv_r[39:32]);

  always_comb begin
    case (uw.xsel)
      XS_X:    xs = x_r;
      XS_XM:   xs = xm_r;
      XS_XE:   xs = xe_r;
      default: xs = x_r;
    endcase
  end

  always_comb begin
    case (uw.kadd)
      KA_NONE: kadd66 = '0;
      KA_HALF: kadd66 = 66'(k_r) >>> 1;
      KA_FULL: kadd66 = 66'(k_r);
      default: kadd66 = '0;
    endcase
  end

  // The single multiplier: x squared or h times the slope
  always_comb begin
    if (uw.op == OP_MH) begin
      mul_a = $signed({1'b0, step_size_r});
      mul_b = t_r;
    end else begin
      mul_a = xs;
      mul_b = xs;
    end
  end

  assign out_load = busy_r && (uw.op == OP_FIN) && (!out_valid_r || !out_stall);

  // Sequencer: item intake, branch conditions and release to the output
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (in_acc) begin
        busy_nxt = 1'b1;
        upc_nxt  = UA_CHECK;
      end
    end else if (out_load) begin
      busy_nxt = 1'b0;
      upc_nxt  = UA_CHECK;
    end else begin
      case (uw.cond)
        J_NEXT:     upc_nxt = upc_r + UPC_W'(1);
        J_ALWAYS:   upc_nxt = uw.target;
        J_CNT_ZERO: upc_nxt = (cnt_r == '0) ? uw.target : upc_r + UPC_W'(1);
        J_DIV_BUSY: upc_nxt = (dcnt_r != '0) ? uw.target : upc_r + UPC_W'(1);
        J_MORE:     upc_nxt = (cnt_r != CNT_W'(1)) ? uw.target : upc_r + UPC_W'(1);
        J_OUT_WAIT: upc_nxt = uw.target;
        default:    upc_nxt = UA_FIN;
      endcase
    end
  end

  // Datapath: one operation per control word
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    xm_nxt   = xm_r;
    xe_nxt   = xe_r;
    ys_nxt   = ys_r;
    t_nxt    = t_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    p_nxt    = p_r;
    dv_nxt   = dv_r;
    drem_nxt = drem_r;
    dcnt_nxt = dcnt_r;
    dneg_nxt = dneg_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    sr       = '0;
    if (!busy_r) begin
      if (in_acc) begin
        x_nxt   = in_start_x;
        y_nxt   = in_start_y;
        cnt_nxt = cnt_load;
        ov_nxt  = 1'b0;
      end
    end else begin
      case (uw.op)
        OP_XM: begin
          sr      = sat32(66'(x_r) + hhalf66);
          xm_nxt  = sr.val;
          acc_nxt = '0;
        end
        OP_XE: begin
          sr     = sat32(66'(x_r) + h66);
          xe_nxt = sr.val;
        end
        OP_YS: begin
          sr     = sat32(66'(y_r) + kadd66);
          ys_nxt = sr.val;
        end
        OP_MSQ, OP_MH: p_nxt = mul_a * mul_b;
        OP_RNDT: begin
          sr    = sat32(rnd66);
          t_nxt = sr.val;
        end
        OP_SUB: begin
          sr    = sat32(66'(ys_r) - 66'(t_r));
          t_nxt = sr.val;
        end
        OP_ONE: begin
          sr    = sat32(66'(t_r) + ONE);
          t_nxt = sr.val;
        end
        OP_RNDK: begin
          sr    = sat32(rnd66);
          k_nxt = sr.val;
        end
        OP_ACC: acc_nxt = acc_r + (uw.dbl ? (kx <<< 1) : kx);
        OP_DINIT: begin
          // Divide by six as a halving, then long division by three
          dv_nxt   = {5'd0, mag36[35:1]};
          dneg_nxt = acc_r[34];
          drem_nxt = '0;
          dcnt_nxt = 3'd4;
        end
        OP_DITER: begin
          dv_nxt   = {dv_r[31:0], dg.q};
          drem_nxt = dg.rem;
          dcnt_nxt = dcnt_r - 3'd1;
        end
        OP_KFIN: begin
          sr    = sat32(dneg_r ? -q66 : q66);
          k_nxt = sr.val;
        end
        OP_YUPD: begin
          sr      = sat32(66'(y_r) + 66'(k_r));
          y_nxt   = sr.val;
          x_nxt   = xe_r;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        default: ;
      endcase
      ov_nxt = ov_r | sr.ov;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= UA_CHECK;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and output payload registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    xm_r   <= xm_nxt;
    xe_r   <= xe_nxt;
    ys_r   <= ys_nxt;
    t_r    <= t_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    p_r    <= p_nxt;
    dv_r   <= dv_nxt;
    drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt;
    dneg_r <= dneg_nxt;
    cnt_r  <= cnt_nxt;
    ov_r   <= ov_nxt;
    if (out_load) begin
      out_x_r  <= x_r;
      out_y_r  <= y_r;
      out_ov_r <= ov_r;
    end
  end

endmodule

`default_nettype wire

// ===== tb/rk4_ode_checker.sv =====
//------------------------------------------------------------------------------
// RK4 integrator result checker
// Watches the input, result and register ports of the integrator. For every
// accepted item it integrates y' = y - x*x + 1 in saturating fixed point and
// queues the end point. It then compares each accepted result, field by field,
// with the oldest queued end point.
//------------------------------------------------------------------------------
`default_nettype none

module rk4_ode_checker #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_STEPS = 1023
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] in_start_x,
  input  wire logic signed [31:0] in_start_y,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_end_x,
  input  wire logic signed [31:0] out_end_y,
  input  wire logic               out_overflow,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      mismatches,
  output int                      waiting_results,
  output int                      points_checked,
  output int                      overflow_seen
);

  import rk4_pkg::*;

  localparam logic [2:0] ADDR_STEP_SIZE  = {REG_STEP_SIZE, 2'b00};
  localparam logic [2:0] ADDR_STEP_COUNT = {REG_STEP_COUNT, 2'b00};

  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;
  localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
  localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

  typedef struct {
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               overflow;
  } rk4_point_t;

  // Register copies as they stand after reset and each write.
  logic [30:0] step_h;
  logic [9:0]  step_n;

  rk4_point_t expected_points[$];
  bit         clamp_hit;
  int         errs      = 0;
  int         checked   = 0;
  int         sat_count = 0;

  // Clamp to the signed 32-bit range and note that saturation happened.
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) begin
      clamp_hit = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clamp_hit = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // Fixed-point product, rounded to nearest with ties upwards.
  function automatic longint mul_q(input longint a, input longint b);
    return clamp_q((a * b + ROUND_HALF) >>> FRAC_BITS);
  endfunction

  // Right-hand side of the ODE: y - x*x + 1.
  function automatic longint slope_q(input longint x, input longint y);
    longint t;
    t = clamp_q(y - mul_q(x, x));
    return clamp_q(t + ONE_Q);
  endfunction

  // Runs the configured number of RK4 steps from one starting point.
  function automatic rk4_point_t integrate_point(input logic signed [31:0] sx,
                                                 input logic signed [31:0] sy,
                                                 input logic [30:0]        h_reg,
                                                 input logic [9:0]         n_reg);
    rk4_point_t r;
    longint     x, y, h, xm, xe, k1, k2, k3, k4, k, sum;
    int         steps;
    clamp_hit = 1'b0;
    x = sx;
    y = sy;
    h = {33'd0, h_reg};
    steps = (n_reg > MAX_STEPS) ? MAX_STEPS : int'(n_reg);
    for (int i = 0; i < steps; i++) begin
      xm = clamp_q(x + (h >>> 1));
      xe = clamp_q(x + h);
      k1 = mul_q(h, slope_q(x, y));
      k2 = mul_q(h, slope_q(xm, clamp_q(y + (k1 >>> 1))));
      k3 = mul_q(h, slope_q(xm, clamp_q(y + (k2 >>> 1))));
      k4 = mul_q(h, slope_q(xe, clamp_q(y + k3)));
      // Weighted sum over six, rounded half away from zero.
      sum = k1 + 2 * k2 + 2 * k3 + k4;
      k = (sum >= 0) ? (sum + 3) / 6 : -((3 - sum) / 6);
      k = clamp_q(k);
      y = clamp_q(y + k);
      x = xe;
    end
    r.end_x    = x[31:0];
    r.end_y    = y[31:0];
    r.overflow = clamp_hit;
    return r;
  endfunction

  // Follow register writes, predict accepted items and check results.
  always @(posedge clk) begin
    rk4_point_t want;
    if (!rst_n) begin
      step_h = 31'd13107;
      step_n = 10'd10;
      expected_points.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_STEP_SIZE:  step_h = pwdata[30:0];
          ADDR_STEP_COUNT: step_n = pwdata[9:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        expected_points.push_back(integrate_point(in_start_x, in_start_y, step_h, step_n));

      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("Result item with none outstanding: end_x %0d, end_y %0d",
                 out_end_x, out_end_y);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (out_end_x !== want.end_x) begin
            $error("end_x: expected %0d, actual %0d", want.end_x, out_end_x);
            errs++;
          end
          if (out_end_y !== want.end_y) begin
            $error("end_y: expected %0d, actual %0d", want.end_y, out_end_y);
            errs++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_overflow);
            errs++;
          end
          checked++;
          if (want.overflow)
            sat_count++;
        end
      end
    end

    mismatches      <= errs;
    waiting_results <= expected_points.size();
    points_checked  <= checked;
    overflow_seen   <= sat_count;
  end

endmodule

`default_nettype wire

// ===== tb/tb_rk4_ode_integrator.sv =====
//------------------------------------------------------------------------------
// RK4 integrator testbench
// Feeds starting points to the integrator in random bursts, under a range of
// step sizes and step counts set through the register port, while the
// receiver stalls at random. A separate checker predicts and compares every
// result; this module makes the stimulus and gives the verdict.
//------------------------------------------------------------------------------
`default_nettype none

module tb_rk4_ode_integrator;

  import rk4_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_STEPS       = 1023;
  localparam int WATCHDOG_LIMIT  = 250000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int TAIL_CYCLES     = 100;

  localparam logic [2:0] ADDR_STEP_SIZE  = {REG_STEP_SIZE, 2'b00};
  localparam logic [2:0] ADDR_STEP_COUNT = {REG_STEP_COUNT, 2'b00};

  typedef enum {MIX_SMALL, MIX_WIDE, MIX_FULL} coord_mix_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [31:0] out_end_x;
  logic signed [31:0] out_end_y;
  logic               out_overflow;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int waiting_results;
  int points_checked;
  int overflow_seen;
  int step_settings = 1;
  bit hold_request  = 1'b0;

  rk4_ode_integrator #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_end_x    (out_end_x),
    .out_end_y    (out_end_y),
    .out_overflow (out_overflow),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  rk4_ode_checker #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_overflow    (out_overflow),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .waiting_results (waiting_results),
    .points_checked  (points_checked),
    .overflow_seen   (overflow_seen)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall pattern in segments, plus one long hold-off on request.
  initial begin : receiver
    int          span;
    stall_mode_t mode;
    forever begin
      if (hold_request) begin
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_request = 1'b0;
      end else begin
        span = $urandom_range(10, 200);
        mode = stall_mode_t'($urandom_range(0, 2));
        for (int c = 0; c < span; c++) begin
          @(posedge clk);
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:     out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // One register write: setup cycle, then access cycle until pready.
  // The caller releases the bus once its last write is done.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Wait until every queued result has been delivered.
  task automatic drain();
    do @(posedge clk); while (waiting_results != 0);
  endtask

  // Idle the block, then set step size and count; unused upper bits get junk.
  task automatic set_steps(input logic [30:0] h, input logic [9:0] n);
    logic junk;
    drain();
    junk = 1'($urandom_range(0, 1));
    write_reg(ADDR_STEP_SIZE, {junk, h});
    write_reg(ADDR_STEP_COUNT, {22'($urandom), n});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_settings++;
  endtask

  // Offer one item and hold it until it is taken.
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
    in_valid   <= 1'b1;
    in_start_x <= x;
    in_start_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // A coordinate: mostly modest values, with wide and extreme ones mixed in.
  function automatic logic signed [31:0] pick_coord(input coord_mix_t mix);
    int roll;
    roll = $urandom_range(0, 9);
    if (mix == MIX_FULL || (mix == MIX_WIDE && roll < 3))
      return $urandom;
    if (mix == MIX_WIDE && roll == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sh00000000;
        default: return -32'sd1;
      endcase
    end
    if (mix == MIX_WIDE && roll < 6)
      return $signed($urandom) >>> $urandom_range(4, 12);
    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // Send a run of items in bursts separated by random gaps.
  task automatic run_points(input int count, input coord_mix_t mix);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        send_point(pick_coord(mix), pick_coord(mix));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic signed [31:0] corner_x [16];
    logic signed [31:0] corner_y [16];
    logic [30:0]        h;
    corner_x = '{32'h00000000, 32'h00000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff,
                 32'hffff0000, 32'h00010000, 32'h01000000, 32'h00b50000,
                 32'h00000000, 32'h00020000, 32'h55555555, 32'haaaaaaaa};
    corner_y = '{32'h00000000, 32'h00008000, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000001,
                 32'h00000000, 32'h00010000, 32'h00000000, 32'h00000000,
                 32'h7fff0000, 32'hfffe0000, 32'haaaaaaaa, 32'h55555555};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Corner points under the reset settings (h = 0.2, ten steps).
    for (int i = 0; i < 16; i++)
      send_point(corner_x[i], corner_y[i]);
    in_valid <= 1'b0;

    // Zero steps: the start point comes straight back.
    set_steps(31'd13107, 10'd0);
    run_points(100, MIX_FULL);

    // Zero step size: nothing moves.
    set_steps(31'd0, 10'd3);
    run_points(60, MIX_WIDE);

    // Largest step while the receiver holds off, so the block backs up.
    set_steps(31'h7fffffff, 10'd1);
    hold_request = 1'b1;
    run_points(100, MIX_WIDE);

    // Smallest step.
    set_steps(31'd1, 10'd2);
    run_points(100, MIX_WIDE);

    // Well-behaved integration, with a full pause halfway through.
    set_steps(31'($urandom_range(1, 32'h0001_0000)), 10'd4);
    run_points(150, MIX_SMALL);
    drain();
    run_points(150, MIX_SMALL);

    // Longest runs: all 1023 steps, with a fine and a coarse step.
    set_steps(31'h0000_0100, 10'd1023);
    run_points(2, MIX_SMALL);
    set_steps(31'd13107, 10'd1023);
    run_points(1, MIX_SMALL);

    // Random settings.
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 2) == 0)
        h = 31'($urandom);
      else
        h = 31'($urandom_range(1, 32'h0004_0000));
      set_steps(h, 10'($urandom_range(0, 12)));
      run_points(80, MIX_WIDE);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Integrated %0d starting points under %0d step settings, %0d of them saturated.",
             points_checked, step_settings, overflow_seen);
    $display("Step counts from 0 to 1023 and step sizes from 0 to the largest were used.");
    if (mismatches == 0 && waiting_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
